[rtl/core/ultrasonic_level_gauge_assert.svh]
// Assertion macros shared by the ultrasonic level gauge RTL.
`ifndef ULTRASONIC_LEVEL_GAUGE_ASSERT_SVH
`define ULTRASONIC_LEVEL_GAUGE_ASSERT_SVH

`define ULG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ULG_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

[rtl/core/ulg_pkg.sv]
// Types and constants of the ultrasonic level gauge.
package ulg_pkg;

   localparam int TICK_W      = 20;
   localparam int IDX_W       = 6;
   localparam int SUM_W       = 22;
   localparam int LEN_W       = 16;
   localparam int GAP_W       = 20;
   localparam int DIST_W      = 17;
   localparam int LEVEL_W     = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int DIV_NUM_W   = 31;
   localparam int DIV_DEN_W   = 16;
   localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [8:0]         SOUND_NUM   = 9'd343;
   localparam logic [7:0]         SOUND_DEN   = 8'd200;
   localparam logic [9:0]         LEVEL_SCALE = 10'd1000;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 10'd1000;
   localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

   typedef enum logic [2:0] {
      PH_TRIG_LOW,
      PH_TRIG_HIGH,
      PH_WAIT_RISE,
      PH_MEASURE,
      PH_SAMPLE_GAP,
      PH_REPORT,
      PH_ROUND_GAP
   } phase_type;

   typedef enum logic [2:0] {
      BK_PASS,
      BK_DIST_START,
      BK_DIST_WAIT,
      BK_LEVEL_PREP,
      BK_LEVEL_START,
      BK_LEVEL_WAIT,
      BK_EMIT
   } back_state_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT,
      CSR_ROUND_SAMPLES,
      CSR_SAMPLE_GAP,
      CSR_ROUND_GAP,
      CSR_MIN_DISTANCE,
      CSR_TANK_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0] timeout_ticks;
      logic [IDX_W-1:0] round_samples;
      logic [GAP_W-1:0] sample_gap_ticks;
      logic [GAP_W-1:0] round_gap_ticks;
      logic [LEN_W-1:0] min_distance;
      logic [LEN_W-1:0] tank_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      timeout_ticks:    16'd30000,
      round_samples:    6'd30,
      sample_gap_ticks: 20'd10000,
      round_gap_ticks:  20'd500000,
      min_distance:     16'd100,
      tank_height:      16'd2000
   };

   typedef struct packed {
      logic echo_level;
   } req_payload_type;

   typedef struct packed {
      logic               trigger_level;
      logic               report_valid;
      logic               status;
      logic [DIST_W-1:0]  distance;
      logic [LEVEL_W-1:0] level_tenths;
      logic [IDX_W-1:0]   valid_samples;
   } rsp_payload_type;

   typedef struct packed {
      logic             report;
      logic             trigger_level;
      logic [SUM_W-1:0] duration_sum;
      logic [IDX_W-1:0] valid_count;
   } job_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/ulg_stream_if.sv]
// Valid/ready stream channel with a typed payload.
interface ulg_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/ultrasonic_level_gauge.sv]
// Top level of the ultrasonic level gauge.
// Each request is one microsecond tick carrying the sampled echo level, and each
// request yields exactly one response with the trigger drive and, on the report tick,
// the averaged distance and fill level of the round. Ordinary ticks flow through at
// one per cycle while the queue has room, with a two-entry job queue between the tick
// sequencer and the result stage. A report tick with samples takes two divisions in a
// shared restoring divider that yields one quotient bit per cycle over 31 bits: the
// average distance, then the fill level if the tank height is nonzero and above it.
// Meanwhile the queue fills; request ready drops until the report response is loaded.
`include "ultrasonic_level_gauge_assert.svh"

module ultrasonic_level_gauge #(
   parameter int TRIG_LOW_TICKS  = 2,
   parameter int TRIG_HIGH_TICKS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   ulg_stream_if.sink                       req_chan,
   ulg_stream_if.source                     rsp_chan,
   input  logic                             csr_we,
   input  logic [ulg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ulg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ulg_pkg::cfg_type      cfg_ff, cfg_in;
   logic                  push_valid;
   logic                  push_ready;
   ulg_pkg::job_type      push_entry;
   logic                  pop_valid;
   logic                  pop_ready;
   ulg_pkg::job_type      pop_entry;
   ulg_pkg::div_req_type  div_req;
   ulg_pkg::div_rsp_type  div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (ulg_pkg::csr_index_type'(csr_index))
            ulg_pkg::CSR_TIMEOUT:       cfg_in.timeout_ticks    = csr_wdata[ulg_pkg::LEN_W-1:0];
            ulg_pkg::CSR_ROUND_SAMPLES: cfg_in.round_samples    = csr_wdata[ulg_pkg::IDX_W-1:0];
            ulg_pkg::CSR_SAMPLE_GAP:    cfg_in.sample_gap_ticks = csr_wdata[ulg_pkg::GAP_W-1:0];
            ulg_pkg::CSR_ROUND_GAP:     cfg_in.round_gap_ticks  = csr_wdata[ulg_pkg::GAP_W-1:0];
            ulg_pkg::CSR_MIN_DISTANCE:  cfg_in.min_distance     = csr_wdata[ulg_pkg::LEN_W-1:0];
            ulg_pkg::CSR_TANK_HEIGHT:   cfg_in.tank_height      = csr_wdata[ulg_pkg::LEN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ulg_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ulg_front #(
      .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
      .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   ulg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   ulg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ulg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_chan  (rsp_chan)
   );

   `ULG_ASSERT_NEVER(a_trigger_not_on_report, clock, reset, rsp_chan.valid && rsp_chan.payload.trigger_level && rsp_chan.payload.report_valid, "trigger driven on a report tick")
   `ULG_ASSERT_IMPLY(a_plain_tick_clean, clock, reset, rsp_chan.valid && !rsp_chan.payload.report_valid, !rsp_chan.payload.status && rsp_chan.payload.distance == '0 && rsp_chan.payload.level_tenths == '0 && rsp_chan.payload.valid_samples == '0, "report fields set on a plain tick")
   `ULG_ASSERT_IMPLY(a_empty_round_clean, clock, reset, rsp_chan.valid && rsp_chan.payload.report_valid && rsp_chan.payload.status, rsp_chan.payload.valid_samples == '0 && rsp_chan.payload.distance == '0 && rsp_chan.payload.level_tenths == '0, "empty round reports data")
   `ULG_ASSERT_IMPLY(a_measured_in_range, clock, reset, rsp_chan.valid && rsp_chan.payload.report_valid && !rsp_chan.payload.status, rsp_chan.payload.distance >= ulg_pkg::DIST_W'(cfg_ff.min_distance) && rsp_chan.payload.level_tenths <= ulg_pkg::LEVEL_MAX && rsp_chan.payload.valid_samples != '0, "measured report out of range")

endmodule

[rtl/core/ulg_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
module ulg_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ulg_pkg::div_req_type div_req,
   output ulg_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ulg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ulg_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [ulg_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [ulg_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [ulg_pkg::DIV_DEN_W:0]   rem_shift;
   logic                          fits;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      rem_shift = {rem_ff, quo_ff[ulg_pkg::DIV_NUM_W-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = ulg_pkg::DIV_CNT_W'(ulg_pkg::DIV_NUM_W - 1);
         quo_in  = div_req.numer;
         rem_in  = '0;
         den_in  = div_req.denom;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = ulg_pkg::DIV_DEN_W'(rem_shift - {1'b0, den_ff});
         end else begin
            rem_in = rem_shift[ulg_pkg::DIV_DEN_W-1:0];
         end
         quo_in = {quo_ff[ulg_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/core/ulg_queue.sv]
// Short job queue between the tick front end and the result back end.
module ulg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  ulg_pkg::job_type push_entry,
   output logic             push_ready,
   output logic             pop_valid,
   output ulg_pkg::job_type pop_entry,
   input  logic             pop_ready
);

   localparam int PTR_W = $clog2(ulg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ulg_pkg::QUEUE_DEPTH + 1);

   ulg_pkg::job_type   slot_ff [ulg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = count_ff != CNT_W'(ulg_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ulg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ulg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/ulg_front.sv]
// Tick sequencer that drives the trigger, times echoes and queues a job per tick.
module ulg_front #(
   parameter int TRIG_LOW_TICKS  = 2,
   parameter int TRIG_HIGH_TICKS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  ulg_pkg::cfg_type cfg,
   ulg_stream_if.sink       req_chan,
   output logic             push_valid,
   output ulg_pkg::job_type push_entry,
   input  logic             push_ready
);

   ulg_pkg::phase_type            phase_ff, phase_in;
   logic [ulg_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [ulg_pkg::TICK_W-1:0]    tick_inc;
   logic [ulg_pkg::IDX_W-1:0]     index_ff, index_in;
   logic [ulg_pkg::IDX_W-1:0]     vcount_ff, vcount_in;
   logic [ulg_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic                          accept;
   logic                          echo;
   logic                          finish;
   logic                          keep;
   logic                          gap_done;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign echo           = req_chan.payload.echo_level;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      index_in  = index_ff;
      vcount_in = vcount_ff;
      sum_in    = sum_ff;
      finish    = 1'b0;
      keep      = 1'b0;
      gap_done  = 1'b0;
      tick_inc  = tick_ff + 1'b1;
      if (accept) begin
         unique case (phase_ff)
            ulg_pkg::PH_TRIG_LOW: begin
               tick_in = tick_inc;
               if (tick_inc >= ulg_pkg::TICK_W'(TRIG_LOW_TICKS)) begin
                  phase_in = ulg_pkg::PH_TRIG_HIGH;
                  tick_in  = '0;
               end
            end
            ulg_pkg::PH_TRIG_HIGH: begin
               tick_in = tick_inc;
               if (tick_inc >= ulg_pkg::TICK_W'(TRIG_HIGH_TICKS)) begin
                  phase_in = ulg_pkg::PH_WAIT_RISE;
                  tick_in  = '0;
               end
            end
            ulg_pkg::PH_WAIT_RISE: begin
               if (echo) begin
                  phase_in = ulg_pkg::PH_MEASURE;
                  tick_in  = ulg_pkg::TICK_W'(1);
               end else begin
                  tick_in = tick_inc;
                  finish  = tick_inc > ulg_pkg::TICK_W'(cfg.timeout_ticks);
               end
            end
            ulg_pkg::PH_MEASURE: begin
               if (echo) begin
                  tick_in = tick_inc;
                  finish  = tick_inc > ulg_pkg::TICK_W'(cfg.timeout_ticks);
               end else begin
                  finish = 1'b1;
                  keep   = 1'b1;
               end
            end
            ulg_pkg::PH_SAMPLE_GAP: begin
               tick_in  = tick_inc;
               gap_done = tick_inc >= ulg_pkg::TICK_W'(cfg.sample_gap_ticks);
            end
            ulg_pkg::PH_REPORT: begin
               index_in  = '0;
               vcount_in = '0;
               sum_in    = '0;
               tick_in   = '0;
               phase_in  = (cfg.round_gap_ticks != '0) ? ulg_pkg::PH_ROUND_GAP
                                                        : ulg_pkg::PH_TRIG_LOW;
            end
            ulg_pkg::PH_ROUND_GAP: begin
               tick_in = tick_inc;
               if (tick_inc >= ulg_pkg::TICK_W'(cfg.round_gap_ticks)) begin
                  phase_in = ulg_pkg::PH_TRIG_LOW;
                  tick_in  = '0;
               end
            end
            default: begin
               phase_in = ulg_pkg::PH_TRIG_LOW;
               tick_in  = '0;
            end
         endcase
         if (finish) begin
            if (keep) begin
               sum_in    = sum_ff + ulg_pkg::SUM_W'(tick_ff);
               vcount_in = vcount_ff + 1'b1;
            end
            index_in = index_ff + 1'b1;
            if (cfg.sample_gap_ticks != '0) begin
               phase_in = ulg_pkg::PH_SAMPLE_GAP;
               tick_in  = '0;
            end else begin
               gap_done = 1'b1;
            end
         end
         if (gap_done) begin
            phase_in = (index_in >= cfg.round_samples) ? ulg_pkg::PH_REPORT
                                                       : ulg_pkg::PH_TRIG_LOW;
            tick_in  = '0;
         end
      end
   end

   always_comb begin
      push_valid                = req_chan.valid;
      push_entry.report         = phase_ff == ulg_pkg::PH_REPORT;
      push_entry.trigger_level  = phase_ff == ulg_pkg::PH_TRIG_HIGH;
      push_entry.duration_sum   = sum_ff;
      push_entry.valid_count    = vcount_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ulg_pkg::PH_TRIG_LOW;
         tick_ff   <= '0;
         index_ff  <= '0;
         vcount_ff <= '0;
         sum_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         index_ff  <= index_in;
         vcount_ff <= vcount_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

[rtl/core/ulg_back.sv]
// Result stage that passes tick results and works out the round report.
module ulg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ulg_pkg::cfg_type      cfg,
   input  logic                  pop_valid,
   input  ulg_pkg::job_type      pop_entry,
   output logic                  pop_ready,
   output ulg_pkg::div_req_type  div_req,
   input  ulg_pkg::div_rsp_type  div_rsp,
   ulg_stream_if.source          rsp_chan
);

   ulg_pkg::back_state_type         state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ulg_pkg::rsp_payload_type        rsp_ff, rsp_in;
   logic [ulg_pkg::DIV_NUM_W-1:0]   numer_ff;
   logic [ulg_pkg::DIV_DEN_W-1:0]   denom_ff;
   logic [ulg_pkg::IDX_W-1:0]       vcount_ff;
   logic [ulg_pkg::DIST_W-1:0]      dist_ff;
   logic [ulg_pkg::LEVEL_W-1:0]     level_ff;
   logic [ulg_pkg::DIV_NUM_W-1:0]   raised;
   logic [ulg_pkg::DIST_W-1:0]      dist_clamp;
   logic [ulg_pkg::LEVEL_W-1:0]     level_clamp;
   logic [ulg_pkg::LEN_W-1:0]       lvl_diff;
   logic                            level_go;
   logic                            out_free;
   logic                            pop_take;
   logic                            needs_div;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign pop_take  = pop_valid && pop_ready;
   assign needs_div = pop_entry.report && (pop_entry.valid_count != '0);
   assign level_go  = (cfg.tank_height != '0) &&
                      (dist_ff < ulg_pkg::DIST_W'(cfg.tank_height));
   assign lvl_diff  = cfg.tank_height - dist_ff[ulg_pkg::LEN_W-1:0];

   always_comb begin
      raised = (div_rsp.quotient < ulg_pkg::DIV_NUM_W'(cfg.min_distance))
             ? ulg_pkg::DIV_NUM_W'(cfg.min_distance) : div_rsp.quotient;
      dist_clamp = (raised > ulg_pkg::DIV_NUM_W'(ulg_pkg::DIST_MAX))
                 ? ulg_pkg::DIST_MAX : raised[ulg_pkg::DIST_W-1:0];
      level_clamp = (div_rsp.quotient > ulg_pkg::DIV_NUM_W'(ulg_pkg::LEVEL_MAX))
                  ? ulg_pkg::LEVEL_MAX : div_rsp.quotient[ulg_pkg::LEVEL_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ulg_pkg::BK_PASS: begin
            if (pop_take && needs_div) begin
               state_in = ulg_pkg::BK_DIST_START;
            end
         end
         ulg_pkg::BK_DIST_START: state_in = ulg_pkg::BK_DIST_WAIT;
         ulg_pkg::BK_DIST_WAIT: begin
            if (div_rsp.done) begin
               state_in = ulg_pkg::BK_LEVEL_PREP;
            end
         end
         ulg_pkg::BK_LEVEL_PREP: begin
            state_in = level_go ? ulg_pkg::BK_LEVEL_START : ulg_pkg::BK_EMIT;
         end
         ulg_pkg::BK_LEVEL_START: state_in = ulg_pkg::BK_LEVEL_WAIT;
         ulg_pkg::BK_LEVEL_WAIT: begin
            if (div_rsp.done) begin
               state_in = ulg_pkg::BK_EMIT;
            end
         end
         ulg_pkg::BK_EMIT: begin
            if (out_free) begin
               state_in = ulg_pkg::BK_PASS;
            end
         end
         default: state_in = ulg_pkg::BK_PASS;
      endcase
   end

   always_comb begin
      pop_ready     = (state_ff == ulg_pkg::BK_PASS) && out_free;
      div_req.start = (state_ff == ulg_pkg::BK_DIST_START) ||
                      (state_ff == ulg_pkg::BK_LEVEL_START);
      div_req.numer = numer_ff;
      div_req.denom = denom_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      if (pop_take && !needs_div) begin
         rsp_valid_in         = 1'b1;
         rsp_in               = '0;
         rsp_in.trigger_level = pop_entry.trigger_level;
         rsp_in.report_valid  = pop_entry.report;
         rsp_in.status        = pop_entry.report;
      end else if ((state_ff == ulg_pkg::BK_EMIT) && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_in               = '0;
         rsp_in.report_valid  = 1'b1;
         rsp_in.distance      = dist_ff;
         rsp_in.level_tenths  = level_ff;
         rsp_in.valid_samples = vcount_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ulg_pkg::BK_PASS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (pop_take && needs_div) begin
         numer_ff  <= ulg_pkg::DIV_NUM_W'(pop_entry.duration_sum) *
                      ulg_pkg::DIV_NUM_W'(ulg_pkg::SOUND_NUM);
         denom_ff  <= ulg_pkg::DIV_DEN_W'(pop_entry.valid_count) *
                      ulg_pkg::DIV_DEN_W'(ulg_pkg::SOUND_DEN);
         vcount_ff <= pop_entry.valid_count;
      end
      if ((state_ff == ulg_pkg::BK_DIST_WAIT) && div_rsp.done) begin
         dist_ff <= dist_clamp;
      end
      if (state_ff == ulg_pkg::BK_LEVEL_PREP) begin
         numer_ff <= ulg_pkg::DIV_NUM_W'(lvl_diff) * ulg_pkg::DIV_NUM_W'(ulg_pkg::LEVEL_SCALE);
         denom_ff <= cfg.tank_height;
         level_ff <= '0;
      end
      if ((state_ff == ulg_pkg::BK_LEVEL_WAIT) && div_rsp.done) begin
         level_ff <= level_clamp;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule
